/* hw/rtl/synth_voice_allocator_defines.svh */
// Assertion macros shared by the voice allocator checker.
`ifndef SYNTH_VOICE_ALLOCATOR_DEFINES_SVH
`define SYNTH_VOICE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SVALLOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SVALLOC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/svalloc_pkg.sv */
// Shared types and constants of the synthesizer voice allocator.
package svalloc_pkg;

  // Default sizes.
  localparam int unsigned VOICES_DEF       = 9;
  localparam int unsigned CHANNELS_DEF     = 16;
  localparam int unsigned DRUM_CHANNEL_DEF = 9;

  // Fixed field widths.
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned KEY_W  = 7;
  localparam int unsigned VEL_W  = 7;
  localparam int unsigned VNUM_W = 4;
  localparam int unsigned ACT_W  = 3;

  // Request kinds; codes five to seven are rejected with an error.
  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE_ON  = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_RESERVE  = 3'd2,
    KIND_RELEASE  = 3'd3,
    KIND_ALL_OFF  = 3'd4
  } kind_e;

  // Result actions.
  typedef enum logic [ACT_W-1:0] {
    ACT_VOICE_ON   = 3'd0,
    ACT_VOICE_OFF  = 3'd1,
    ACT_NOT_FOUND  = 3'd2,
    ACT_DROPPED    = 3'd3,
    ACT_OK         = 3'd4,
    ACT_WARNING    = 3'd5,
    ACT_ERROR      = 3'd6,
    ACT_POOL_RESET = 3'd7
  } action_e;

endpackage

/* hw/rtl/synth_voice_allocator.sv */
// Voice allocator: assigns synthesizer voices to MIDI notes from an ordered
// free pool, with per-channel lists of sounding voices and stealing of the
// oldest drum-channel voice when the pool is empty. One request is handled at
// a time. The per-voice links and key data live in three small RAMs with a
// registered read, so every list step is a read followed by a write. A
// note-off walks the channel list one voice at a time; an all-notes-off stops
// each voice on the channel and then rebuilds the pool. A stalled full output
// register holds the sequencer in its emit state. After reset the block
// rebuilds the pool with in_stall_o held high. Results leave through an output
// register, so a finished result may wait there while the next one is built.
module synth_voice_allocator #(
  parameter int unsigned VOICES       = svalloc_pkg::VOICES_DEF,
  parameter int unsigned CHANNELS     = svalloc_pkg::CHANNELS_DEF,
  parameter int unsigned DRUM_CHANNEL = svalloc_pkg::DRUM_CHANNEL_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [svalloc_pkg::KIND_W-1:0]  kind_i,
  input  logic [svalloc_pkg::CHAN_W-1:0]  midi_channel_i,
  input  logic [svalloc_pkg::KEY_W-1:0]   note_key_i,
  input  logic [svalloc_pkg::VEL_W-1:0]   note_velocity_i,
  input  logic [svalloc_pkg::VNUM_W-1:0]  voice_number_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [svalloc_pkg::ACT_W-1:0]   action_o,
  output logic [svalloc_pkg::VNUM_W-1:0]  voice_id_o,
  output logic [svalloc_pkg::CHAN_W-1:0]  out_channel_o,
  output logic [svalloc_pkg::KEY_W-1:0]   out_key_o,
  output logic [svalloc_pkg::VEL_W-1:0]   out_velocity_o,
  output logic                            last_o
);

  localparam int unsigned VW    = $clog2(VOICES + 1);
  localparam int unsigned VIW   = $clog2(VOICES);
  localparam int unsigned LISTS = CHANNELS + 1;
  localparam int unsigned LW    = $clog2(LISTS);
  localparam int unsigned CW    = svalloc_pkg::CHAN_W;
  localparam int unsigned KW    = svalloc_pkg::KEY_W;
  localparam int unsigned EW    = svalloc_pkg::VEL_W;
  localparam int unsigned DW    = CW + KW;
  localparam logic [VW-1:0] NONE = '1;
  localparam logic [VW-1:0] NV   = VW'(VOICES);
  localparam bit DRUM_OK = (DRUM_CHANNEL < CHANNELS);
  localparam logic [LW-1:0] DRUM_LIST = DRUM_OK ? LW'(DRUM_CHANNEL + 1) : '0;
  localparam logic [LW-1:0] POOL = '0;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_DECIDE  = 11'b000_0000_0010,
    ST_WALK_RD = 11'b000_0000_0100,
    ST_WALK_CK = 11'b000_0000_1000,
    ST_RD      = 11'b000_0001_0000,
    ST_RM      = 11'b000_0010_0000,
    ST_ADD1    = 11'b000_0100_0000,
    ST_ADD2    = 11'b000_1000_0000,
    ST_EMIT    = 11'b001_0000_0000,
    ST_RB_CLR  = 11'b010_0000_0000,
    ST_RB_STEP = 11'b100_0000_0000
  } state_e;

  // Micro-operation carried through the read, unlink and append steps.
  typedef enum logic [2:0] {
    MOP_STOP,
    MOP_TAKE,
    MOP_RSV,
    MOP_REL,
    MOP_RB
  } mop_e;

  typedef struct packed {
    logic [CW-1:0] chan;
    logic [KW-1:0] note;
  } voice_rec_t;

  // Control state.
  state_e              state_q, state_d;
  logic                boot_q, boot_d;
  mop_e                mop_q, mop_d;
  logic                fin_q, fin_d;
  logic [VW-1:0]       cur_v_q, cur_v_d;
  logic [VW-1:0]       steps_q, steps_d;
  logic [VW-1:0]       rb_i_q, rb_i_d;
  logic [LW-1:0]       add_list_q, add_list_d;
  logic [VOICES-1:0]   active_q, active_d;
  logic [VOICES-1:0]   reserved_q, reserved_d;
  logic [VW-1:0]       head_q [LISTS];
  logic [VW-1:0]       head_d [LISTS];
  logic [VW-1:0]       tail_q [LISTS];
  logic [VW-1:0]       tail_d [LISTS];

  // Latched request.
  logic [svalloc_pkg::KIND_W-1:0] kind_q;
  logic [CW-1:0]                  ch_q;
  logic [KW-1:0]                  key_q;
  logic [EW-1:0]                  vel_q;
  logic [svalloc_pkg::VNUM_W-1:0] vn_q;

  // Pending result.
  svalloc_pkg::action_e e_act_q, e_act_d;
  logic [VW-1:0]        e_v_q, e_v_d;
  logic [CW-1:0]        e_ch_q, e_ch_d;
  logic [KW-1:0]        e_key_q, e_key_d;
  logic [EW-1:0]        e_vel_q, e_vel_d;
  logic                 e_last_q, e_last_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  svalloc_pkg::action_e out_act_q;
  logic [VW-1:0]        out_v_q;
  logic [CW-1:0]        out_ch_q;
  logic [KW-1:0]        out_key_q;
  logic [EW-1:0]        out_vel_q;
  logic                 out_last_q;

  // RAM ports.
  logic            dat_we, nxt_we, prv_we;
  logic [VIW-1:0]  dat_wa, nxt_wa, prv_wa;
  voice_rec_t      dat_wd, dat_rd;
  logic [VW-1:0]   nxt_wd, prv_wd, nxt_rd, prv_rd;

  logic            in_acc, can_emit, is_on, ch_ok, vn_ok;
  logic [LW-1:0]   ch_list, rm_list;
  logic [VIW-1:0]  vn_idx, cur_idx;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign can_emit = !out_valid_q || !out_stall_i;
  assign is_on    = (kind_q == svalloc_pkg::KIND_NOTE_ON) && (vel_q != '0);
  assign ch_ok    = ({1'b0, ch_q} < 5'(CHANNELS));
  assign vn_ok    = ({1'b0, vn_q} < 5'(VOICES));
  assign ch_list  = LW'(ch_q) + LW'(1);
  assign vn_idx   = vn_q[VIW-1:0];
  assign cur_idx  = cur_v_q[VIW-1:0];
  assign rm_list  = (mop_q == MOP_STOP) ? (LW'(dat_rd.chan) + LW'(1)) : POOL;

  function automatic logic vld(input logic [VW-1:0] x);
    return x < NV;
  endfunction

  // Per-voice key data, next links and previous links.
  svalloc_ram #(.WIDTH(DW), .DEPTH(VOICES)) u_dat_ram (
    .clk_i  (clk_i),
    .we_i   (dat_we),
    .waddr_i(dat_wa),
    .wdata_i(dat_wd),
    .raddr_i(cur_idx),
    .rdata_o(dat_rd)
  );

  svalloc_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_nxt_ram (
    .clk_i  (clk_i),
    .we_i   (nxt_we),
    .waddr_i(nxt_wa),
    .wdata_i(nxt_wd),
    .raddr_i(cur_idx),
    .rdata_o(nxt_rd)
  );

  svalloc_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_prv_ram (
    .clk_i  (clk_i),
    .we_i   (prv_we),
    .waddr_i(prv_wa),
    .wdata_i(prv_wd),
    .raddr_i(cur_idx),
    .rdata_o(prv_rd)
  );

  // Sequencer: decides each step of a request and updates lists and flags.
  always_comb begin
    state_d    = state_q;
    boot_d     = boot_q;
    mop_d      = mop_q;
    fin_d      = fin_q;
    cur_v_d    = cur_v_q;
    steps_d    = steps_q;
    rb_i_d     = rb_i_q;
    add_list_d = add_list_q;
    active_d   = active_q;
    reserved_d = reserved_q;
    head_d     = head_q;
    tail_d     = tail_q;
    e_act_d    = e_act_q;
    e_v_d      = e_v_q;
    e_ch_d     = e_ch_q;
    e_key_d    = e_key_q;
    e_vel_d    = e_vel_q;
    e_last_d   = e_last_q;
    dat_we     = 1'b0;
    dat_wa     = cur_idx;
    dat_wd     = '0;
    nxt_we     = 1'b0;
    nxt_wa     = cur_idx;
    nxt_wd     = NONE;
    prv_we     = 1'b0;
    prv_wa     = cur_idx;
    prv_wd     = NONE;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          steps_d = '0;
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        e_v_d    = '0;
        e_ch_d   = '0;
        e_key_d  = '0;
        e_vel_d  = '0;
        e_last_d = 1'b1;
        state_d  = ST_EMIT;
        if (is_on) begin
          if (!ch_ok) begin
            e_act_d = svalloc_pkg::ACT_DROPPED;
          end else if (vld(head_q[POOL])) begin
            cur_v_d = head_q[POOL];
            mop_d   = MOP_TAKE;
            fin_d   = 1'b1;
            state_d = ST_RD;
          end else if (DRUM_OK && vld(head_q[DRUM_LIST])) begin
            cur_v_d = head_q[DRUM_LIST];
            mop_d   = MOP_STOP;
            fin_d   = 1'b0;
            state_d = ST_RD;
          end else begin
            e_act_d = svalloc_pkg::ACT_DROPPED;
          end
        end else begin
          unique case (kind_q)
            svalloc_pkg::KIND_NOTE_ON, svalloc_pkg::KIND_NOTE_OFF: begin
              if (ch_ok) begin
                cur_v_d = head_q[ch_list];
                steps_d = '0;
                state_d = ST_WALK_RD;
              end else begin
                e_act_d = svalloc_pkg::ACT_NOT_FOUND;
              end
            end
            svalloc_pkg::KIND_RESERVE: begin
              if (!vn_ok) begin
                e_act_d = svalloc_pkg::ACT_ERROR;
              end else if (reserved_q[vn_idx]) begin
                e_act_d = svalloc_pkg::ACT_WARNING;
              end else begin
                cur_v_d = VW'(vn_q);
                mop_d   = active_q[vn_idx] ? MOP_STOP : MOP_RSV;
                fin_d   = !active_q[vn_idx];
                state_d = ST_RD;
              end
            end
            svalloc_pkg::KIND_RELEASE: begin
              if (!vn_ok) begin
                e_act_d = svalloc_pkg::ACT_ERROR;
              end else if (!reserved_q[vn_idx]) begin
                e_act_d = svalloc_pkg::ACT_WARNING;
              end else begin
                reserved_d[vn_idx] = 1'b0;
                cur_v_d    = VW'(vn_q);
                mop_d      = MOP_REL;
                add_list_d = POOL;
                e_act_d    = svalloc_pkg::ACT_OK;
                state_d    = ST_ADD1;
              end
            end
            svalloc_pkg::KIND_ALL_OFF: begin
              if (ch_ok && vld(head_q[ch_list]) && (steps_q < NV)) begin
                cur_v_d = head_q[ch_list];
                mop_d   = MOP_STOP;
                fin_d   = 1'b0;
                steps_d = steps_q + VW'(1);
                state_d = ST_RD;
              end else begin
                state_d = ST_RB_CLR;
              end
            end
            default: begin
              e_act_d = svalloc_pkg::ACT_ERROR;
            end
          endcase
        end
      end

      // Key search along the channel list: each voice is read, then its key is checked.
      ST_WALK_RD: begin
        if (vld(cur_v_q) && (steps_q < NV)) begin
          state_d = ST_WALK_CK;
        end else begin
          e_act_d  = svalloc_pkg::ACT_NOT_FOUND;
          e_last_d = 1'b1;
          state_d  = ST_EMIT;
        end
      end

      ST_WALK_CK: begin
        if (dat_rd.note == key_q) begin
          mop_d   = MOP_STOP;
          fin_d   = 1'b1;
          state_d = ST_RD;
        end else begin
          cur_v_d = nxt_rd;
          steps_d = steps_q + VW'(1);
          state_d = ST_WALK_RD;
        end
      end

      ST_RD: begin
        state_d = ST_RM;
      end

      // Unlink the voice from its list using the links just read.
      ST_RM: begin
        if (vld(prv_rd)) begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd[VIW-1:0];
          nxt_wd = nxt_rd;
        end else begin
          head_d[rm_list] = nxt_rd;
        end
        if (vld(nxt_rd)) begin
          prv_we = 1'b1;
          prv_wa = nxt_rd[VIW-1:0];
          prv_wd = prv_rd;
        end else begin
          tail_d[rm_list] = prv_rd;
        end
        e_last_d = fin_q;
        unique case (mop_q)
          MOP_STOP: begin
            active_d[cur_idx] = 1'b0;
            add_list_d = POOL;
            e_act_d    = svalloc_pkg::ACT_VOICE_OFF;
            e_v_d      = cur_v_q;
            e_ch_d     = dat_rd.chan;
            e_key_d    = dat_rd.note;
            e_vel_d    = '0;
            state_d    = ST_ADD1;
          end
          MOP_TAKE: begin
            dat_we = 1'b1;
            dat_wd = '{chan: ch_q, note: key_q};
            active_d[cur_idx] = 1'b1;
            add_list_d = ch_list;
            e_act_d    = svalloc_pkg::ACT_VOICE_ON;
            e_v_d      = cur_v_q;
            e_ch_d     = ch_q;
            e_key_d    = key_q;
            e_vel_d    = vel_q;
            state_d    = ST_ADD1;
          end
          default: begin
            reserved_d[cur_idx] = 1'b1;
            e_act_d = svalloc_pkg::ACT_OK;
            state_d = ST_EMIT;
          end
        endcase
      end

      // Append the voice at the tail of the target list.
      ST_ADD1: begin
        prv_we = 1'b1;
        prv_wd = tail_q[add_list_q];
        if (vld(tail_q[add_list_q])) begin
          nxt_we = 1'b1;
          nxt_wa = tail_q[add_list_q][VIW-1:0];
          nxt_wd = cur_v_q;
        end else begin
          head_d[add_list_q] = cur_v_q;
        end
        tail_d[add_list_q] = cur_v_q;
        state_d = ST_ADD2;
      end

      ST_ADD2: begin
        nxt_we = 1'b1;
        nxt_wd = NONE;
        if (mop_q == MOP_RB) begin
          rb_i_d  = rb_i_q + VW'(1);
          state_d = ST_RB_STEP;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (can_emit) begin
          state_d = e_last_q ? ST_IDLE : ST_DECIDE;
        end
      end

      // Pool rebuild: empty every list, then append unreserved voices in order.
      ST_RB_CLR: begin
        for (int unsigned l = 0; l < LISTS; l++) begin
          head_d[l] = NONE;
          tail_d[l] = NONE;
        end
        rb_i_d  = '0;
        state_d = ST_RB_STEP;
      end

      ST_RB_STEP: begin
        if (rb_i_q == NV) begin
          if (boot_q) begin
            boot_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            e_act_d  = svalloc_pkg::ACT_POOL_RESET;
            e_v_d    = '0;
            e_ch_d   = '0;
            e_key_d  = '0;
            e_vel_d  = '0;
            e_last_d = 1'b1;
            state_d  = ST_EMIT;
          end
        end else if (reserved_q[rb_i_q[VIW-1:0]]) begin
          rb_i_d = rb_i_q + VW'(1);
        end else begin
          dat_we     = 1'b1;
          dat_wa     = rb_i_q[VIW-1:0];
          dat_wd     = '0;
          active_d[rb_i_q[VIW-1:0]] = 1'b0;
          cur_v_d    = rb_i_q;
          mop_d      = MOP_RB;
          add_list_d = POOL;
          state_d    = ST_ADD1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if ((state_q == ST_EMIT) && can_emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RB_CLR;
      boot_q      <= 1'b1;
      mop_q       <= MOP_STOP;
      fin_q       <= 1'b0;
      cur_v_q     <= '0;
      steps_q     <= '0;
      rb_i_q      <= '0;
      add_list_q  <= '0;
      active_q    <= '0;
      reserved_q  <= '0;
      e_last_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int unsigned l = 0; l < LISTS; l++) begin
        head_q[l] <= NONE;
        tail_q[l] <= NONE;
      end
    end else begin
      state_q     <= state_d;
      boot_q      <= boot_d;
      mop_q       <= mop_d;
      fin_q       <= fin_d;
      cur_v_q     <= cur_v_d;
      steps_q     <= steps_d;
      rb_i_q      <= rb_i_d;
      add_list_q  <= add_list_d;
      active_q    <= active_d;
      reserved_q  <= reserved_d;
      e_last_q    <= e_last_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      ch_q   <= midi_channel_i;
      key_q  <= note_key_i;
      vel_q  <= note_velocity_i;
      vn_q   <= voice_number_i;
    end
    e_act_q <= e_act_d;
    e_v_q   <= e_v_d;
    e_ch_q  <= e_ch_d;
    e_key_q <= e_key_d;
    e_vel_q <= e_vel_d;
    if ((state_q == ST_EMIT) && can_emit) begin
      out_act_q  <= e_act_q;
      out_v_q    <= e_v_q;
      out_ch_q   <= e_ch_q;
      out_key_q  <= e_key_q;
      out_vel_q  <= e_vel_q;
      out_last_q <= e_last_q;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign action_o       = out_act_q;
  assign voice_id_o     = svalloc_pkg::VNUM_W'(out_v_q);
  assign out_channel_o  = out_ch_q;
  assign out_key_o      = out_key_q;
  assign out_velocity_o = out_vel_q;
  assign last_o         = out_last_q;

endmodule

/* hw/rtl/svalloc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module svalloc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/svalloc_chk.sv */
// Port-level checker of the voice allocator and its bind.
`include "synth_voice_allocator_defines.svh"

module svalloc_chk #(
  parameter int unsigned VOICES = svalloc_pkg::VOICES_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [svalloc_pkg::ACT_W-1:0]  action_o,
  input logic [svalloc_pkg::VNUM_W-1:0] voice_id_o,
  input logic [svalloc_pkg::CHAN_W-1:0] out_channel_o,
  input logic [svalloc_pkg::KEY_W-1:0]  out_key_o,
  input logic [svalloc_pkg::VEL_W-1:0]  out_velocity_o,
  input logic                           last_o
);

  logic is_voice;
  assign is_voice = (action_o == svalloc_pkg::ACT_VOICE_ON) ||
                    (action_o == svalloc_pkg::ACT_VOICE_OFF);

  // A stalled result stays valid with its action, voice id and last flag held.
  `SVALLOC_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(action_o) && $stable(voice_id_o) && $stable(last_o),
    "stalled result changed")

  // One request at a time: after a transaction the input stalls.
  `SVALLOC_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
    "input accepted while busy")

  // Voice results name a real voice.
  `SVALLOC_ASSERT_NOW(a_voice_range, out_valid_o && is_voice,
    {1'b0, voice_id_o} < 5'(VOICES), "voice id out of range")

  // Non-voice results carry zero fields.
  `SVALLOC_ASSERT_NOW(a_zero_fields, out_valid_o && !is_voice,
    voice_id_o == '0 && out_channel_o == '0 && out_key_o == '0 && out_velocity_o == '0,
    "non-voice result has fields set")

  // A started voice always has a nonzero velocity.
  `SVALLOC_ASSERT_NOW(a_on_velocity, out_valid_o && action_o == svalloc_pkg::ACT_VOICE_ON,
    out_velocity_o != '0, "voice on with zero velocity")

endmodule

bind synth_voice_allocator svalloc_chk #(.VOICES(VOICES)) u_svalloc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .action_o      (action_o),
  .voice_id_o    (voice_id_o),
  .out_channel_o (out_channel_o),
  .out_key_o     (out_key_o),
  .out_velocity_o(out_velocity_o),
  .last_o        (last_o)
);
